// File: rtl/spq_pkg.sv
// shared types, sizes and status codes of the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_BITS = 32;
  localparam int PRIO_BITS = 8;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  localparam int FILL_W    = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] payload;
    logic [7:0]  prio;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic [1:0]  status;
    logic [4:0]  fill;
  } out_beat_t;

  typedef struct packed {
    logic                 insert;
    logic                 remove;
    logic [DATA_BITS-1:0] data;
    logic [PRIO_BITS-1:0] prio;
  } cell_ctl_t;

endpackage

// File: rtl/sorted_priority_queue.sv
// sorted priority queue top level: chain of spq_cell slots and result register
// depends on spq_pkg and spq_cell
//
// usage: each input beat on in_* is an insert (kind 0, payload and prio) or a
// remove (kind 1). every beat yields exactly one output beat on out_* with the
// removed data, a status code and the fill level after the beat.
// entries sit in a row of cells sorted by descending priority, slot 0 is the
// head; an insert lands behind all entries of equal or higher priority, so
// equal priorities leave first in first out.
// output: the result of a beat is registered and presented in the cycle after it is accepted.
// throughput: one beat per cycle while no result waits or out_ready_i is high;
// every cell compares its priority with the incoming one and shifts toward or
// away from the head in the same cycle.
// stall: while out_ready_i is low with a result waiting, in_ready_o is low;
// the result register holds its beat until taken.
// reset: rst_ni low empties the queue (fill 0) and drops any pending result;
// the cell contents are not cleared, only the fill count.
module sorted_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::in_beat_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spq_pkg::out_beat_t out_o
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::COUNT_W;

  logic [CW-1:0]                 count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  spq_pkg::out_beat_t            out_q, out_d;
  spq_pkg::cell_ctl_t            ctl;
  logic                          accept, is_full, is_empty;
  logic [CW-1:0]                 fill_next;

  logic [spq_pkg::DATA_BITS-1:0] cell_data [CAP];
  logic [spq_pkg::PRIO_BITS-1:0] cell_prio [CAP];
  logic [CAP-1:0]                cell_ge;
  logic [CAP-1:0]                cell_occ;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CW'(CAP));
  assign is_empty   = (count_q == '0);

  always_comb begin
    ctl.insert = accept && (in_i.kind == spq_pkg::KIND_INSERT) && !is_full;
    ctl.remove = accept && (in_i.kind == spq_pkg::KIND_REMOVE) && !is_empty;
    ctl.data   = in_i.payload[spq_pkg::DATA_BITS-1:0];
    ctl.prio   = in_i.prio[spq_pkg::PRIO_BITS-1:0];
  end

  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      logic                          left_ge;
      logic [spq_pkg::DATA_BITS-1:0] left_data, right_data;
      logic [spq_pkg::PRIO_BITS-1:0] left_prio, right_prio;

      assign cell_occ[g] = (CW'(g) < count_q);

      if (g == 0) begin : g_head
        assign left_ge   = 1'b1;
        assign left_data = cell_data[g];
        assign left_prio = cell_prio[g];
      end else begin : g_body
        assign left_ge   = cell_ge[g-1];
        assign left_data = cell_data[g-1];
        assign left_prio = cell_prio[g-1];
      end

      if (g == CAP - 1) begin : g_tail
        assign right_data = cell_data[g];
        assign right_prio = cell_prio[g];
      end else begin : g_mid
        assign right_data = cell_data[g+1];
        assign right_prio = cell_prio[g+1];
      end

      spq_cell u_cell (
        .clk_i       (clk_i),
        .ctl_i       (ctl),
        .occ_i       (cell_occ[g]),
        .left_ge_i   (left_ge),
        .left_data_i (left_data),
        .left_prio_i (left_prio),
        .right_data_i(right_data),
        .right_prio_i(right_prio),
        .data_o      (cell_data[g]),
        .prio_o      (cell_prio[g]),
        .ge_o        (cell_ge[g])
      );
    end
  endgenerate

  always_comb begin
    count_d = count_q;
    if (ctl.insert) begin
      count_d = count_q + CW'(1);
    end else if (ctl.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  assign fill_next = count_d;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d    = 1'b1;
      out_d.out_data = '0;
      out_d.fill     = 5'(fill_next);
      if (in_i.kind == spq_pkg::KIND_INSERT) begin
        out_d.status = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else if (is_empty) begin
        out_d.status = spq_pkg::ST_EMPTY;
      end else begin
        out_d.status   = spq_pkg::ST_REMOVED;
        out_d.out_data = 32'(cell_data[0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/spq_cell.sv
// one slot of the sorted chain: holds an entry and trades with its neighbors
// depends on spq_pkg
module spq_cell (
  input  logic                          clk_i,
  input  spq_pkg::cell_ctl_t            ctl_i,
  input  logic                          occ_i,
  input  logic                          left_ge_i,
  input  logic [spq_pkg::DATA_BITS-1:0] left_data_i,
  input  logic [spq_pkg::PRIO_BITS-1:0] left_prio_i,
  input  logic [spq_pkg::DATA_BITS-1:0] right_data_i,
  input  logic [spq_pkg::PRIO_BITS-1:0] right_prio_i,
  output logic [spq_pkg::DATA_BITS-1:0] data_o,
  output logic [spq_pkg::PRIO_BITS-1:0] prio_o,
  output logic                          ge_o
);

  logic [spq_pkg::DATA_BITS-1:0] data_q, data_d;
  logic [spq_pkg::PRIO_BITS-1:0] prio_q, prio_d;
  logic                          ge;

  assign ge = occ_i && (prio_q >= ctl_i.prio);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    if (ctl_i.insert && !ge) begin
      if (left_ge_i) begin
        data_d = ctl_i.data;
        prio_d = ctl_i.prio;
      end else begin
        data_d = left_data_i;
        prio_d = left_prio_i;
      end
    end else if (ctl_i.remove) begin
      data_d = right_data_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;
  assign ge_o   = ge;

endmodule

// File: tb/tb_sorted_priority_queue.sv
// testbench for sorted_priority_queue: directed and random insert/remove beats,
// every result checked against an in-bench sorted-list model of the queue
// depends on spq_pkg and the sorted_priority_queue rtl
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  localparam int TOTAL_BEATS   = 1150;
  localparam int TAIL_BEATS    = 100;
  localparam int LONG_HOLD_AT  = 250;
  localparam int LONG_HOLD_LEN = 150;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    bit                 drain_first;
    spq_pkg::in_beat_t  beat;
  } pending_beat_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  spq_pkg::in_beat_t  in_beat   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_beat_t out_beat;

  pending_beat_t      beats_to_send[$];
  spq_pkg::out_beat_t expected_results[$];

  logic [spq_pkg::DATA_BITS-1:0] held_data [spq_pkg::CAPACITY];
  logic [spq_pkg::PRIO_BITS-1:0] held_prio [spq_pkg::CAPACITY];
  int                            held_count = 0;

  spq_pkg::out_beat_t predicted;
  spq_pkg::out_beat_t want_beat;
  pending_beat_t      next_beat;
  int                 send_gap      = 0;
  int                 hold_left     = 0;
  bit                 long_hold_done = 1'b0;
  int                 n_insert = 0, n_remove = 0, n_full = 0, n_empty = 0;
  int                 peak_fill       = 0;
  int                 results_checked = 0;
  int                 mismatches      = 0;
  int                 cycle_count     = 0;

  sorted_priority_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat)
  );

  always #6 clk_i = ~clk_i;

  // sorted list model, head at slot 0, new entry behind equal priorities
  function automatic spq_pkg::out_beat_t predict_outcome(spq_pkg::in_beat_t b);
    spq_pkg::out_beat_t r;
    int                 slot;
    int                 k;
    r    = '0;
    slot = 0;
    if (b.kind == spq_pkg::KIND_INSERT) begin
      if (held_count >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        while (slot < held_count && held_prio[slot] >= b.prio) slot++;
        for (k = held_count; k > slot; k--) begin
          held_data[k] = held_data[k-1];
          held_prio[k] = held_prio[k-1];
        end
        held_data[slot] = b.payload;
        held_prio[slot] = b.prio;
        held_count++;
        r.status = spq_pkg::ST_INSERTED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.out_data = held_data[0];
        for (k = 1; k < held_count; k++) begin
          held_data[k-1] = held_data[k];
          held_prio[k-1] = held_prio[k];
        end
        held_count--;
        r.status = spq_pkg::ST_REMOVED;
      end
    end
    r.fill = spq_pkg::FILL_W'(held_count);
    return r;
  endfunction

  task automatic queue_beat(input logic kind, input logic [31:0] data,
                            input logic [7:0] pr, input bit drain);
    pending_beat_t p;
    p.drain_first  = drain;
    p.beat.kind    = kind;
    p.beat.payload = data;
    p.beat.prio    = pr;
    beats_to_send.push_back(p);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = predict_outcome(in_beat);
        expected_results.push_back(predicted);
        case (predicted.status)
          spq_pkg::ST_INSERTED: n_insert++;
          spq_pkg::ST_REMOVED:  n_remove++;
          spq_pkg::ST_EMPTY:    n_empty++;
          spq_pkg::ST_FULL:     n_full++;
          default: ;
        endcase
        if (int'(predicted.fill) > peak_fill) peak_fill = int'(predicted.fill);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (beats_to_send[0].drain_first && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          next_beat = beats_to_send.pop_front();
          in_beat  <= next_beat.beat;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected beat: out_data %h status %0d fill %0d",
                 out_beat.out_data, out_beat.status, out_beat.fill);
          mismatches++;
        end else begin
          want_beat = expected_results.pop_front();
          if (out_beat.out_data !== want_beat.out_data) begin
            $error("out_data expected %h actual %h", want_beat.out_data, out_beat.out_data);
            mismatches++;
          end
          if (out_beat.status !== want_beat.status) begin
            $error("status expected %0d actual %0d", want_beat.status, out_beat.status);
            mismatches++;
          end
          if (out_beat.fill !== want_beat.fill) begin
            $error("fill expected %0d actual %0d", want_beat.fill, out_beat.fill);
            mismatches++;
          end
        end
        results_checked++;
        if (results_checked == LONG_HOLD_AT && !long_hold_done) begin
          long_hold_done = 1'b1;
          hold_left = LONG_HOLD_LEN;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (beats_to_send.size() > TAIL_BEATS && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int          mode;
    int          len;
    int          pr_sel;
    bit          drain;
    logic        kind;
    logic [7:0]  pr;

    // directed: empty remove, field extremes, ties, drain to empty
    queue_beat(spq_pkg::KIND_REMOVE, 32'h0,        8'h00, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'h0,        8'h00, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'hffffffff, 8'hff, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'ha5a5a5a5, 8'h80, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'h5a5a5a5a, 8'h80, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'h00000001, 8'h00, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'h80000000, 8'h01, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'h7fffffff, 8'hfe, 1'b0);
    queue_beat(spq_pkg::KIND_INSERT, 32'h12345678, 8'hff, 1'b0);
    for (int i = 0; i < 9; i++) begin
      queue_beat(spq_pkg::KIND_REMOVE, $urandom, 8'($urandom), 1'b0);
    end
    queue_beat(spq_pkg::KIND_REMOVE, 32'hffffffff, 8'hff, 1'b0);

    // random episodes: insert bursts to full, remove bursts to empty, mixes
    while (beats_to_send.size() < TOTAL_BEATS) begin
      mode   = $urandom_range(0, 5);
      len    = $urandom_range(1, 20);
      pr_sel = $urandom_range(0, 3);
      drain  = (beats_to_send.size() < 30) || ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0, 1:    kind = ($urandom_range(0, 9) == 0) ? spq_pkg::KIND_REMOVE
                                                      : spq_pkg::KIND_INSERT;
          2:       kind = ($urandom_range(0, 9) == 0) ? spq_pkg::KIND_INSERT
                                                      : spq_pkg::KIND_REMOVE;
          default: kind = $urandom_range(0, 1) ? spq_pkg::KIND_REMOVE
                                               : spq_pkg::KIND_INSERT;
        endcase
        case (pr_sel)
          0:       pr = 8'($urandom_range(0, 255));
          1:       pr = 8'($urandom_range(0, 3));
          2:       pr = 8'($urandom_range(252, 255));
          default: pr = $urandom_range(0, 1) ? 8'hff : 8'h00;
        endcase
        queue_beat(kind, $urandom, pr, drain && i == 0);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_to_send.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d inserts, %0d removes, %0d dropped while full, %0d removes on empty",
             n_insert, n_remove, n_full, n_empty);
    $display("peak fill %0d, %0d results checked, %0d mismatches",
             peak_fill, results_checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
